@@ rtl/plwc_pkg.sv @@
`default_nettype none
package plwc_pkg;

  // Register indexes on the configuration port
  localparam logic [7:0] REG_NODE_ADDRESS = 8'd0;
  localparam logic [7:0] REG_LISTEN_ENABLE = 8'd1;
  localparam logic [7:0] REG_GUARD_WINDOW = 8'd2;
  localparam logic [7:0] REG_MAX_MISSED = 8'd3;
  localparam logic [7:0] REG_POLL_COMMAND_CODE = 8'd4;

  // Register reset values
  localparam logic [7:0] RST_NODE_ADDRESS = 8'd0;
  localparam logic RST_LISTEN_ENABLE = 1'b0;
  localparam logic [15:0] RST_GUARD_WINDOW = 16'd500;
  localparam logic [7:0] RST_MAX_MISSED = 8'd3;
  localparam logic [7:0] RST_POLL_COMMAND_CODE = 8'd1;

  // Item opcodes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_PACKET = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_NONE = 3'd0;
  localparam logic [2:0] ST_POLL_OK = 3'd1;
  localparam logic [2:0] ST_AUTH_FAIL = 3'd2;
  localparam logic [2:0] ST_NOT_FOR_NODE = 3'd3;
  localparam logic [2:0] ST_REPLAY = 3'd4;
  localparam logic [2:0] ST_WOKE = 3'd5;
  localparam logic [2:0] ST_MISSED = 3'd6;
  localparam logic [2:0] ST_FALLBACK = 3'd7;

  typedef struct packed {
    logic        opcode;
    logic [31:0] now_ms;
    logic        auth_ok;
    logic [7:0]  command_code;
    logic [7:0]  dest_addr;
    logic [15:0] epoch;
    logic [15:0] sequence_req;
    logic [31:0] period_ms;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        radio_mode;
    logic        schedule_acquired;
    logic [7:0]  missed_count;
    logic [31:0] window_start;
    logic [31:0] window_end;
  } result_t;

  typedef struct packed {
    logic [7:0]  node_address;
    logic        listen_enable;
    logic [15:0] guard_window;
    logic [7:0]  max_missed;
    logic [7:0]  poll_command_code;
  } cfg_t;

  // a is ahead of b in 16-bit sequence space
  function automatic logic is_forward16(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] d;
    d = a - b;
    return (d != 16'd0) && !d[15];
  endfunction

endpackage
`default_nettype wire

@@ rtl/plwc_in_if.sv @@
`default_nettype none
interface plwc_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] now_ms;
  logic        auth_ok;
  logic [7:0]  command_code;
  logic [7:0]  dest_addr;
  logic [15:0] epoch;
  logic [15:0] sequence_req;
  logic [31:0] period_ms;

  modport source (
    output valid, opcode, now_ms, auth_ok, command_code, dest_addr, epoch,
           sequence_req, period_ms,
    input  ready
  );
  modport sink (
    input  valid, opcode, now_ms, auth_ok, command_code, dest_addr, epoch,
           sequence_req, period_ms,
    output ready
  );
endinterface
`default_nettype wire

@@ rtl/plwc_out_if.sv @@
`default_nettype none
interface plwc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        radio_mode;
  logic        schedule_acquired;
  logic [7:0]  missed_count;
  logic [31:0] window_start;
  logic [31:0] window_end;

  modport source (
    output valid, status, radio_mode, schedule_acquired, missed_count,
           window_start, window_end,
    input  ready
  );
  modport sink (
    input  valid, status, radio_mode, schedule_acquired, missed_count,
           window_start, window_end,
    output ready
  );
endinterface
`default_nettype wire

@@ rtl/plwc_cfg_if.sv @@
`default_nettype none
interface plwc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/plwc_cfg_regs.sv @@
`default_nettype none
module plwc_cfg_regs (
  input  wire logic      clk,
  input  wire logic      rst_n,
  plwc_cfg_if.sink       cfg_ch,
  output plwc_pkg::cfg_t cfg
);

  plwc_pkg::cfg_t cfg_r;
  plwc_pkg::cfg_t cfg_nxt;
  logic           wr_en;

  // always takes a write; unknown indexes are dropped
  assign cfg_ch.ready = 1'b1;
  assign wr_en = cfg_ch.valid;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_ch.index)
        plwc_pkg::REG_NODE_ADDRESS:      cfg_nxt.node_address = cfg_ch.data[7:0];
        plwc_pkg::REG_LISTEN_ENABLE:     cfg_nxt.listen_enable = cfg_ch.data[0];
        plwc_pkg::REG_GUARD_WINDOW:      cfg_nxt.guard_window = cfg_ch.data;
        plwc_pkg::REG_MAX_MISSED:        cfg_nxt.max_missed = cfg_ch.data[7:0];
        plwc_pkg::REG_POLL_COMMAND_CODE: cfg_nxt.poll_command_code = cfg_ch.data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.node_address <= plwc_pkg::RST_NODE_ADDRESS;
      cfg_r.listen_enable <= plwc_pkg::RST_LISTEN_ENABLE;
      cfg_r.guard_window <= plwc_pkg::RST_GUARD_WINDOW;
      cfg_r.max_missed <= plwc_pkg::RST_MAX_MISSED;
      cfg_r.poll_command_code <= plwc_pkg::RST_POLL_COMMAND_CODE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

@@ rtl/plwc_sched.sv @@
`default_nettype none
module plwc_sched (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire plwc_pkg::item_t item,
  input  wire plwc_pkg::cfg_t  cfg,
  output plwc_pkg::result_t    res
);

  // Schedule and replay state
  logic        asleep_r, asleep_nxt;
  logic        sched_r, sched_nxt;
  logic [7:0]  missed_r, missed_nxt;
  logic [31:0] next_poll_r, next_poll_nxt;   // last poll time + interval
  logic [31:0] open_r, open_nxt;
  logic [31:0] close_r, close_nxt;
  logic        gw_seen_r, gw_seen_nxt;
  logic [15:0] gw_epoch_r, gw_epoch_nxt;
  logic [15:0] gw_seq_r, gw_seq_nxt;

  logic [31:0] half;
  logic [31:0] poll_next;
  logic [31:0] win_base;
  logic        replay_ok;
  logic [7:0]  missed_inc;
  logic [2:0]  status;

  assign half = {17'd0, cfg.guard_window[15:1]};
  assign poll_next = item.now_ms + item.period_ms;
  assign missed_inc = missed_r + 8'd1;

  // Gateway replay check
  always_comb begin
    if (!gw_seen_r) begin
      replay_ok = 1'b1;
    end else if (item.epoch == gw_epoch_r) begin
      replay_ok = plwc_pkg::is_forward16(item.sequence_req, gw_seq_r);
    end else begin
      replay_ok = plwc_pkg::is_forward16(item.epoch, gw_epoch_r);
    end
  end

  // Item decode and state update
  always_comb begin
    asleep_nxt = asleep_r;
    sched_nxt = sched_r;
    missed_nxt = missed_r;
    next_poll_nxt = next_poll_r;
    gw_seen_nxt = gw_seen_r;
    gw_epoch_nxt = gw_epoch_r;
    gw_seq_nxt = gw_seq_r;
    win_base = next_poll_r;
    open_nxt = open_r;
    close_nxt = close_r;
    status = plwc_pkg::ST_NONE;
    if (item.opcode == plwc_pkg::OP_PACKET) begin
      if (!item.auth_ok) begin
        status = plwc_pkg::ST_AUTH_FAIL;
      end else if (item.command_code != cfg.poll_command_code ||
                   item.dest_addr != cfg.node_address) begin
        status = plwc_pkg::ST_NOT_FOR_NODE;
      end else if (!replay_ok) begin
        status = plwc_pkg::ST_REPLAY;
      end else begin
        status = plwc_pkg::ST_POLL_OK;
        gw_seen_nxt = 1'b1;
        gw_epoch_nxt = item.epoch;
        gw_seq_nxt = item.sequence_req;
        next_poll_nxt = poll_next;
        missed_nxt = 8'd0;
        if (cfg.listen_enable) begin
          sched_nxt = 1'b1;
          asleep_nxt = 1'b1;
          win_base = poll_next;
          open_nxt = poll_next - half;
          close_nxt = poll_next + half;
        end
      end
    end else if (cfg.listen_enable && sched_r) begin
      if (asleep_r) begin
        if (item.now_ms >= open_r) begin
          asleep_nxt = 1'b0;
          status = plwc_pkg::ST_WOKE;
        end
      end else if (item.now_ms >= close_r) begin
        if (missed_inc >= cfg.max_missed) begin
          // give up on the schedule, stay in receive
          sched_nxt = 1'b0;
          missed_nxt = 8'd0;
          asleep_nxt = 1'b0;
          status = plwc_pkg::ST_FALLBACK;
        end else begin
          missed_nxt = missed_inc;
          asleep_nxt = 1'b1;
          open_nxt = win_base - half;
          close_nxt = win_base + half;
          status = plwc_pkg::ST_MISSED;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      asleep_r <= 1'b0;
      sched_r <= 1'b0;
      missed_r <= 8'd0;
      next_poll_r <= 32'd0;
      open_r <= 32'd0;
      close_r <= 32'd0;
      gw_seen_r <= 1'b0;
      gw_epoch_r <= 16'd0;
      gw_seq_r <= 16'd0;
    end else if (step) begin
      asleep_r <= asleep_nxt;
      sched_r <= sched_nxt;
      missed_r <= missed_nxt;
      next_poll_r <= next_poll_nxt;
      open_r <= open_nxt;
      close_r <= close_nxt;
      gw_seen_r <= gw_seen_nxt;
      gw_epoch_r <= gw_epoch_nxt;
      gw_seq_r <= gw_seq_nxt;
    end
  end

  // Result shows state after the item
  assign res = {status, asleep_nxt, sched_nxt, missed_nxt, open_nxt, close_nxt};

endmodule
`default_nettype wire

@@ rtl/poll_listen_window_controller_core.sv @@
`default_nettype none
// A taken word goes from the input register to the result register (out_ch).
// Throughput: one word per cycle; the input register advances whenever the
// result register is empty or being drained, and state updates in that move.
// Reset (rst_n low, synchronous) empties both stages, clears the schedule and
// replay state and loads the configuration registers with their defaults.
module poll_listen_window_controller_core (
  input wire logic  clk,
  input wire logic  rst_n,
  plwc_in_if.sink   in_ch,
  plwc_out_if.source out_ch,
  plwc_cfg_if.sink  cfg_ch
);

  plwc_pkg::cfg_t    cfg;
  plwc_pkg::item_t   item_r, item_nxt;
  plwc_pkg::result_t res;
  plwc_pkg::result_t res_r;
  logic              in_vld_r, in_vld_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic              out_load;
  logic              in_take;

  plwc_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  plwc_sched u_sched (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (out_load),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // Stage handshakes
  assign out_load = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || out_load;
  assign in_take = in_ch.valid && in_ch.ready;

  always_comb begin
    item_nxt.opcode = in_ch.opcode;
    item_nxt.now_ms = in_ch.now_ms;
    item_nxt.auth_ok = in_ch.auth_ok;
    item_nxt.command_code = in_ch.command_code;
    item_nxt.dest_addr = in_ch.dest_addr;
    item_nxt.epoch = in_ch.epoch;
    item_nxt.sequence_req = in_ch.sequence_req;
    item_nxt.period_ms = in_ch.period_ms;
  end

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (out_load) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (out_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  // Control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= item_nxt;
    end
    if (out_load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.status = res_r.status;
  assign out_ch.radio_mode = res_r.radio_mode;
  assign out_ch.schedule_acquired = res_r.schedule_acquired;
  assign out_ch.missed_count = res_r.missed_count;
  assign out_ch.window_start = res_r.window_start;
  assign out_ch.window_end = res_r.window_end;

endmodule
`default_nettype wire

@@ sim/poll_listen_window_controller_core_tb.sv @@
module poll_listen_window_controller_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import plwc_pkg::*;

  // index with no register behind it, writes must be dropped
  localparam logic [7:0] REG_UNUSED = 8'd9;

  typedef struct {
    item_t       word;
    int unsigned gap;
  } queued_word_t;

  logic clk;
  logic rst_n;

  plwc_in_if  in_ch ();
  plwc_out_if out_ch ();
  plwc_cfg_if cfg_ch ();

  poll_listen_window_controller_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // scheduler shadow: register copy plus window and gateway state
  cfg_t        regs;
  logic        asleep;
  logic        sched_on;
  logic [7:0]  miss_cnt;
  logic [31:0] poll_at;
  logic [31:0] poll_period;
  logic [31:0] win_open;
  logic [31:0] win_close;
  logic        gw_known;
  logic [15:0] gw_epoch;
  logic [15:0] gw_seq;

  queued_word_t tx_words[$];
  result_t      due_reports[$];
  queued_word_t head;
  logic         holding;
  item_t        shown;
  bit           tx_quiet;
  bit           rx_quiet;
  int unsigned  rx_wait;
  int           errors;
  int           words_queued;
  int           results_seen;
  int           reg_writes;
  int           status_hits[8];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned idle_draw(input bit quiet);
    return quiet ? 0 : $urandom_range(0, 13);
  endfunction

  // a ahead of b in 16-bit half-space order
  function automatic logic seq_ahead(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] d;
    d = a - b;
    return (d != 16'd0) && (d < 16'h8000);
  endfunction

  // listen window centered on the predicted poll, guard width wide
  function automatic void set_window();
    logic [31:0] mid;
    logic [31:0] half;
    mid = poll_at + poll_period;
    half = {16'd0, regs.guard_window} >> 1;
    win_open = mid - half;
    win_close = mid + half;
  endfunction

  // advance the shadow by one word, return the report it should produce
  function automatic result_t schedule_step(input item_t w);
    result_t r;
    logic    fresh;
    r.status = ST_NONE;
    if (w.opcode == OP_PACKET) begin
      if (!w.auth_ok) begin
        r.status = ST_AUTH_FAIL;
      end else if (w.command_code != regs.poll_command_code ||
                   w.dest_addr != regs.node_address) begin
        r.status = ST_NOT_FOR_NODE;
      end else begin
        // replay guard: first sighting, same epoch moving on, or newer epoch
        if (!gw_known) begin
          fresh = 1'b1;
        end else if (w.epoch == gw_epoch) begin
          fresh = seq_ahead(w.sequence_req, gw_seq);
        end else begin
          fresh = seq_ahead(w.epoch, gw_epoch);
        end
        if (!fresh) begin
          r.status = ST_REPLAY;
        end else begin
          gw_known = 1'b1;
          gw_epoch = w.epoch;
          gw_seq = w.sequence_req;
          r.status = ST_POLL_OK;
          poll_period = w.period_ms;
          poll_at = w.now_ms;
          miss_cnt = 8'd0;
          if (regs.listen_enable) begin
            sched_on = 1'b1;
            set_window();
            asleep = 1'b1;
          end
        end
      end
    end else if (regs.listen_enable && sched_on) begin
      // plain unsigned compares, no wrap handling
      if (asleep) begin
        if (w.now_ms >= win_open) begin
          asleep = 1'b0;
          r.status = ST_WOKE;
        end
      end else if (w.now_ms >= win_close) begin
        miss_cnt = miss_cnt + 8'd1;
        if (miss_cnt >= regs.max_missed) begin
          sched_on = 1'b0;
          miss_cnt = 8'd0;
          poll_at = 32'd0;
          asleep = 1'b0;
          r.status = ST_FALLBACK;
        end else begin
          asleep = 1'b1;
          set_window();
          r.status = ST_MISSED;
        end
      end
    end
    r.radio_mode = asleep;
    r.schedule_acquired = sched_on;
    r.missed_count = miss_cnt;
    r.window_start = win_open;
    r.window_end = win_close;
    return r;
  endfunction

  function automatic void field_check(input string name, input logic [31:0] want,
                                      input logic [31:0] seen);
    if (seen !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, seen);
      errors++;
    end
  endfunction

  function automatic item_t tick_word(input logic [31:0] t);
    item_t w;
    w.opcode = OP_TICK;
    w.now_ms = t;
    // packet fields are don't-care on ticks, so scramble them
    w.auth_ok = 1'($urandom);
    w.command_code = 8'($urandom);
    w.dest_addr = 8'($urandom);
    w.epoch = 16'($urandom);
    w.sequence_req = 16'($urandom);
    w.period_ms = $urandom;
    return w;
  endfunction

  function automatic item_t poll_word(input logic [31:0] t, input logic [7:0] cmd,
                                      input logic [7:0] dst, input logic [15:0] ep,
                                      input logic [15:0] sq, input logic [31:0] ivl);
    item_t w;
    w.opcode = OP_PACKET;
    w.now_ms = t;
    w.auth_ok = 1'b1;
    w.command_code = cmd;
    w.dest_addr = dst;
    w.epoch = ep;
    w.sequence_req = sq;
    w.period_ms = ivl;
    return w;
  endfunction

  task automatic queue_word(input item_t w);
    queued_word_t q;
    q.word = w;
    q.gap = idle_draw(tx_quiet);
    tx_words.insert(tx_words.size(), q);
    words_queued++;
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_NODE_ADDRESS:      regs.node_address = val[7:0];
      REG_LISTEN_ENABLE:     regs.listen_enable = val[0];
      REG_GUARD_WINDOW:      regs.guard_window = val;
      REG_MAX_MISSED:        regs.max_missed = val[7:0];
      REG_POLL_COMMAND_CODE: regs.poll_command_code = val[7:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // sender idles until every queued word has been reported back
  task automatic wait_drained();
    while (results_seen != words_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // input driver: each word waits out its own gap, then stays up until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      holding = 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        due_reports.insert(due_reports.size(), schedule_step(shown));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (!holding && tx_words.size() != 0) begin
          head = tx_words.pop_front();
          holding = 1'b1;
        end
        if (holding && head.gap != 0) begin
          head.gap--;
          in_ch.valid <= 1'b0;
        end else if (holding) begin
          shown = head.word;
          holding = 1'b0;
          in_ch.valid <= 1'b1;
          in_ch.opcode <= shown.opcode;
          in_ch.now_ms <= shown.now_ms;
          in_ch.auth_ok <= shown.auth_ok;
          in_ch.command_code <= shown.command_code;
          in_ch.dest_addr <= shown.dest_addr;
          in_ch.epoch <= shown.epoch;
          in_ch.sequence_req <= shown.sequence_req;
          in_ch.period_ms <= shown.period_ms;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.status = out_ch.status;
        got.radio_mode = out_ch.radio_mode;
        got.schedule_acquired = out_ch.schedule_acquired;
        got.missed_count = out_ch.missed_count;
        got.window_start = out_ch.window_start;
        got.window_end = out_ch.window_end;
        results_seen++;
        if (due_reports.size() == 0) begin
          $display("%0t: unexpected word, expected none, got %h", $time, got);
          errors++;
        end else begin
          want = due_reports.pop_front();
          status_hits[want.status]++;
          field_check("status", 32'(want.status), 32'(got.status));
          field_check("radio_mode", 32'(want.radio_mode), 32'(got.radio_mode));
          field_check("schedule_acquired", 32'(want.schedule_acquired),
                      32'(got.schedule_acquired));
          field_check("missed_count", 32'(want.missed_count), 32'(got.missed_count));
          field_check("window_start", want.window_start, got.window_start);
          field_check("window_end", want.window_end, got.window_end);
        end
        if (results_seen % 50 == 0) rx_quiet = ($urandom_range(0, 2) == 0);
        rx_wait = idle_draw(rx_quiet);
      end
      if (rx_wait != 0) begin
        rx_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #2000000;
    $display("FAIL poll_listen_window_controller_core");
    $finish;
  end

  // stimulus
  initial begin
    item_t       w;
    logic [31:0] t_now;
    logic [31:0] ivl;
    logic [15:0] g_ep;
    logic [15:0] g_sq;
    logic [7:0]  g_node;
    logic [7:0]  g_cmd;
    logic [15:0] d;
    logic [15:0] gw;
    logic [7:0]  mm;
    int          pick;

    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_TICK;
    in_ch.now_ms = '0;
    in_ch.auth_ok = 1'b0;
    in_ch.command_code = '0;
    in_ch.dest_addr = '0;
    in_ch.epoch = '0;
    in_ch.sequence_req = '0;
    in_ch.period_ms = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    holding = 1'b0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    regs.node_address = RST_NODE_ADDRESS;
    regs.listen_enable = RST_LISTEN_ENABLE;
    regs.guard_window = RST_GUARD_WINDOW;
    regs.max_missed = RST_MAX_MISSED;
    regs.poll_command_code = RST_POLL_COMMAND_CODE;
    asleep = 1'b0;
    sched_on = 1'b0;
    miss_cnt = '0;
    poll_at = '0;
    poll_period = '0;
    win_open = '0;
    win_close = '0;
    gw_known = 1'b0;
    gw_epoch = '0;
    gw_seq = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers: continuous receive, check filters, ordering and replay guard
    queue_word(tick_word(32'd0));
    w = poll_word(32'd10, 8'd1, 8'd0, 16'd5, 16'd10, 32'd100);
    w.auth_ok = 1'b0;
    queue_word(w);
    queue_word(poll_word(32'd20, 8'd2, 8'd0, 16'd5, 16'd10, 32'd100));
    queue_word(poll_word(32'd30, 8'd1, 8'd9, 16'd5, 16'd10, 32'd100));
    queue_word(poll_word(32'd40, 8'd1, 8'd0, 16'd5, 16'd10, 32'd100));
    queue_word(poll_word(32'd50, 8'd1, 8'd0, 16'd5, 16'd10, 32'd100));
    queue_word(poll_word(32'd60, 8'd1, 8'd0, 16'd5, 16'd9, 32'd100));
    queue_word(poll_word(32'd70, 8'd1, 8'd0, 16'd5, 16'd32778, 32'd100));
    queue_word(poll_word(32'd80, 8'd1, 8'd0, 16'd5, 16'd11, 32'd100));
    queue_word(poll_word(32'd90, 8'd1, 8'd0, 16'd4, 16'd12, 32'd100));
    queue_word(poll_word(32'd100, 8'd1, 8'd0, 16'd6, 16'd0, 32'd100));
    wait_drained();

    // windowed mode: open/close edges, missed window, fallback, time wrap
    write_reg(REG_NODE_ADDRESS, 16'hFFA5);
    write_reg(REG_POLL_COMMAND_CODE, 16'h005A);
    write_reg(REG_LISTEN_ENABLE, 16'hFFFF);
    write_reg(REG_GUARD_WINDOW, 16'd1000);
    write_reg(REG_MAX_MISSED, 16'd2);
    write_reg(REG_UNUSED, 16'hFFFF);
    queue_word(poll_word(32'd1000, 8'h5A, 8'hA5, 16'd6, 16'd1, 32'd5000));
    queue_word(tick_word(32'd5499));
    queue_word(tick_word(32'd5500));
    queue_word(tick_word(32'd6500));
    queue_word(tick_word(32'd6500));
    queue_word(tick_word(32'd7000));
    queue_word(poll_word(32'hFFFF_FF00, 8'h5A, 8'hA5, 16'd6, 16'd2, 32'd200));
    queue_word(tick_word(32'hFFFF_FFFF));
    queue_word(tick_word(32'd0));
    wait_drained();

    // all-ones extremes, zero missed limit falls back on the first miss
    write_reg(REG_MAX_MISSED, 16'hFF00);
    write_reg(REG_GUARD_WINDOW, 16'hFFFF);
    write_reg(REG_NODE_ADDRESS, 16'h00FF);
    write_reg(REG_POLL_COMMAND_CODE, 16'hFFFF);
    queue_word(poll_word(32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'd7, 16'hFFFF, 32'hFFFF_FFFF));
    queue_word(poll_word(32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'h8007, 16'd0, 32'd0));
    queue_word(tick_word(32'hFFFF_FFFF));
    queue_word(tick_word(32'hFFFF_FFFF));
    wait_drained();

    // random phases, each under its own register setting
    g_ep = 16'd9;
    g_sq = 16'($urandom);
    t_now = $urandom_range(0, 100000);
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin gw = 16'($urandom_range(1, 3000)); mm = 8'd1; end
        1: begin gw = 16'($urandom); mm = 8'd3; end
        2: begin gw = 16'd0; mm = 8'd0; end
        3: begin gw = 16'hFFFF; mm = 8'd255; end
        default: begin
          gw = 16'($urandom_range(100, 2000));
          mm = 8'($urandom_range(1, 4));
        end
      endcase
      d = 16'($urandom);
      g_node = d[7:0];
      write_reg(REG_NODE_ADDRESS, d);
      d = 16'($urandom);
      g_cmd = d[7:0];
      write_reg(REG_POLL_COMMAND_CODE, d);
      d = 16'($urandom);
      d[0] = (p != 1);
      write_reg(REG_LISTEN_ENABLE, d);
      write_reg(REG_GUARD_WINDOW, gw);
      d = 16'($urandom);
      d[7:0] = mm;
      write_reg(REG_MAX_MISSED, d);
      if (p == 3) t_now = 32'hFFFF_F000;

      for (int n = 0; n < 80; n++) begin
        if (n % 40 == 0) tx_quiet = ($urandom_range(0, 2) == 0);
        if (p == 2 && n == 40) wait_drained();
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          t_now = t_now + $urandom_range(0, 600);
          queue_word(tick_word(t_now));
        end else if (pick < 75) begin
          // good poll from the gateway, now and then after a gateway reboot
          t_now = t_now + $urandom_range(0, 300);
          if ($urandom_range(0, 9) == 0) begin
            g_ep = g_ep + 16'($urandom_range(1, 3));
            g_sq = 16'($urandom);
          end else begin
            g_sq = g_sq + 16'($urandom_range(1, 4));
          end
          ivl = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(200, 2500);
          queue_word(poll_word(t_now, g_cmd, g_node, g_ep, g_sq, ivl));
        end else if (pick < 85) begin
          // replayed or stale sequence number
          queue_word(poll_word(t_now, g_cmd, g_node, g_ep,
                               g_sq - 16'($urandom_range(0, 2)), $urandom));
        end else if (pick < 93) begin
          w = poll_word(t_now, g_cmd, g_node, g_ep, g_sq + 16'd1, $urandom);
          case ($urandom_range(0, 2))
            0: w.auth_ok = 1'b0;
            1: w.dest_addr = g_node ^ 8'($urandom_range(1, 255));
            default: w.command_code = g_cmd ^ 8'($urandom_range(1, 255));
          endcase
          queue_word(w);
        end else begin
          // unconstrained word
          w.opcode = 1'($urandom);
          w.now_ms = $urandom;
          w.auth_ok = 1'($urandom);
          w.command_code = 8'($urandom);
          w.dest_addr = 8'($urandom);
          w.epoch = 16'($urandom);
          w.sequence_req = 16'($urandom);
          w.period_ms = $urandom;
          queue_word(w);
        end
      end
      wait_drained();
    end

    $display("Run covered %0d words across %0d register writes, incl. wrapped time.",
             words_queued, reg_writes);
    $display("Status counts none/poll/auth/addr/replay/woke/missed/fallback: %0d %0d %0d %0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3]);
    $display("  %0d %0d %0d %0d",
             status_hits[4], status_hits[5], status_hits[6], status_hits[7]);
    if (errors == 0) begin
      $display("PASS poll_listen_window_controller_core");
    end else begin
      $display("FAIL poll_listen_window_controller_core");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/plwc_pkg.sv
rtl/plwc_in_if.sv
rtl/plwc_out_if.sv
rtl/plwc_cfg_if.sv
rtl/plwc_cfg_regs.sv
rtl/plwc_sched.sv
rtl/poll_listen_window_controller_core.sv
sim/poll_listen_window_controller_core_tb.sv
